>>> hw/rtl/cbd_pkg.sv
`timescale 1ns / 1ps

package cbd_pkg;

	localparam int SIZE_BITS_DEF = 31;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef enum logic [1:0] {
		ST_ZERO    = 2'd0,
		ST_CLEAN   = 2'd1,
		ST_NO_CRLF = 2'd2,
		ST_TRUNC   = 2'd3
	} end_status_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        payload_valid;
		logic        finished;
		end_status_t end_status;
	} cbd_result_t;

endpackage

>>> hw/rtl/cbd_core.sv
`timescale 1ns / 1ps

module cbd_core
	import cbd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [7:0]  body_byte,
	input  logic        body_end,
	output cbd_result_t res
);

	typedef enum logic [2:0] {
		PH_LINE_START = 3'd0,
		PH_LINE       = 3'd1,
		PH_DATA       = 3'd2,
		PH_SKIP_A     = 3'd3,
		PH_SKIP_B     = 3'd4,
		PH_DONE       = 3'd5
	} phase_t;

	localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

	phase_t               phase_q, phase_d;
	logic [SIZE_BITS-1:0] size_accum_q, size_accum_d;
	logic                 digits_closed_q, digits_closed_d;
	logic                 prev_was_cr_q, prev_was_cr_d;
	logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;

	logic                 hex_ok;
	logic [3:0]           hex_val;
	logic [SIZE_BITS+3:0] accum_ext;

	// Hex digit decode
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		case (body_byte) inside
			[8'h30:8'h39]: hex_val = 4'(body_byte - 8'h30);
			[8'h61:8'h66]: hex_val = 4'(body_byte - 8'h61 + 8'd10);
			[8'h41:8'h46]: hex_val = 4'(body_byte - 8'h41 + 8'd10);
			default:       hex_ok  = 1'b0;
		endcase
	end

	assign accum_ext = {size_accum_q, hex_val};

	always_comb begin
		phase_d         = phase_q;
		size_accum_d    = size_accum_q;
		digits_closed_d = digits_closed_q;
		prev_was_cr_d   = prev_was_cr_q;
		bytes_left_d    = bytes_left_q;
		res.payload_byte  = 8'd0;
		res.payload_valid = 1'b0;
		res.finished      = body_end;
		res.end_status    = ST_ZERO;

		case (phase_q)
			PH_LINE_START, PH_LINE: begin
				phase_d = PH_LINE;
				if (hex_ok && !digits_closed_q) begin
					// saturate when nonzero bits shift out of the size field
					if (accum_ext[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
						size_accum_d = SIZE_MAX;
					end else begin
						size_accum_d = accum_ext[SIZE_BITS-1:0];
					end
				end else if (!hex_ok) begin
					digits_closed_d = 1'b1;
				end
				if (body_byte == CHAR_LF && prev_was_cr_q) begin
					if (size_accum_d == '0) begin
						phase_d = PH_DONE;
					end else begin
						bytes_left_d = size_accum_d;
						phase_d      = PH_DATA;
					end
					prev_was_cr_d = 1'b0;
				end else begin
					prev_was_cr_d = (body_byte == CHAR_CR);
				end
			end
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = body_byte;
				bytes_left_d      = bytes_left_q - 1'b1;
				if (bytes_left_d == '0) begin
					phase_d = PH_SKIP_A;
				end
			end
			PH_SKIP_A: begin
				phase_d = PH_SKIP_B;
			end
			PH_SKIP_B: begin
				phase_d         = PH_LINE_START;
				size_accum_d    = '0;
				digits_closed_d = 1'b0;
				prev_was_cr_d   = 1'b0;
			end
			default: begin
			end
		endcase

		if (body_end) begin
			case (phase_d)
				PH_LINE:                           res.end_status = ST_NO_CRLF;
				PH_DATA:                           res.end_status = ST_TRUNC;
				PH_LINE_START, PH_SKIP_A, PH_SKIP_B: res.end_status = ST_CLEAN;
				default:                           res.end_status = ST_ZERO;
			endcase
			// restart for the next body
			phase_d         = PH_LINE_START;
			size_accum_d    = '0;
			digits_closed_d = 1'b0;
			prev_was_cr_d   = 1'b0;
			bytes_left_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_LINE_START;
			size_accum_q    <= '0;
			digits_closed_q <= 1'b0;
			prev_was_cr_q   <= 1'b0;
			bytes_left_q    <= '0;
		end else if (acc) begin
			phase_q         <= phase_d;
			size_accum_q    <= size_accum_d;
			digits_closed_q <= digits_closed_d;
			prev_was_cr_q   <= prev_was_cr_d;
			bytes_left_q    <= bytes_left_d;
		end
	end

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && body_end) |=> (phase_q == PH_LINE_START && bytes_left_q == '0))
		else $error("state not cleared after final beat");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == PH_DONE && !body_end) |=> (phase_q == PH_DONE))
		else $error("decoding resumed after zero chunk");

	a_data_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (res.payload_valid && bytes_left_q != '0))
		else $error("data phase with no bytes owed");

endmodule

>>> hw/rtl/cbd_out_buf.sv
`timescale 1ns / 1ps

module cbd_out_buf
	import cbd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cbd_result_t push_data,
	output logic        full,
	output logic        out_valid,
	input  logic        out_stall,
	output cbd_result_t out_data
);

	logic        main_valid_q;
	cbd_result_t main_q;
	logic        skid_valid_q;
	cbd_result_t skid_q;
	logic        pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid beat held with empty output register");

endmodule

>>> hw/rtl/chunked_body_decoder.sv
`timescale 1ns / 1ps
// Result beats leave from a registered output buffer; the decode itself is combinational.
// Throughput: one byte per cycle while in_stall is low; one decode state update per beat.
// A two-entry output buffer (output register plus skid) keeps input open while a
// result waits; input stalls only when both entries are full.
// Reset (arst_n low, asynchronous): decoder returns to the start of a size line, buffer empties.

module chunked_body_decoder
	import cbd_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] body_byte,
	input  logic       body_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic       finished,
	output logic [1:0] end_status
);

	logic        in_acc;
	cbd_result_t core_res;
	cbd_result_t out_res;

	// Accept a beat whenever the skid entry is free.
	assign in_acc = in_valid && !in_stall;

	// Decode one byte per beat: size line parsing, data pass-through, CRLF skip.
	cbd_core #(
		.SIZE_BITS(SIZE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (in_acc),
		.body_byte (body_byte),
		.body_end  (body_end),
		.res       (core_res)
	);

	// Hold results until the downstream side takes them.
	cbd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_data (core_res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign payload_byte  = out_res.payload_byte;
	assign payload_valid = out_res.payload_valid;
	assign finished      = out_res.finished;
	assign end_status    = out_res.end_status;

endmodule

>>> tb/chunked_body_decoder_tb.sv
`timescale 1ns / 1ps

module chunked_body_decoder_tb
	import cbd_pkg::*;
();

	// Decoder phases, tracked beat by beat alongside the block
	typedef enum int {
		P_LINE_START,
		P_LINE,
		P_DATA,
		P_SKIP_A,
		P_SKIP_B,
		P_DONE
	} dec_phase_t;

	localparam longint unsigned SIZE_CAP = (64'd1 << SIZE_BITS_DEF) - 64'd1;
	localparam int HOLD_CYCLES = 150;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] body_byte;
	logic       body_end;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       finished;
	logic [1:0] end_status;

	// Decode state mirrored from the block
	dec_phase_t               dec_phase;
	logic [SIZE_BITS_DEF-1:0] size_acc;
	logic [SIZE_BITS_DEF-1:0] bytes_left;
	logic                     digits_closed;
	logic                     prev_cr;

	cbd_result_t decoded_q[$];   // decoded beats still owed by the block
	logic [7:0]  body_q[$];      // body under construction
	int          errors = 0;
	int          bytes_sent = 0;
	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	bit          hold_toggle = 1'b0;  // flip to ask the receiver for a long hold-off
	bit          hold_seen = 1'b0;
	int          hold_left = 0;  // cycles the receiver must still hold off
	int          stall_run = 0;

	chunked_body_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.body_byte    (body_byte),
		.body_end     (body_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.finished     (finished),
		.end_status   (end_status)
	);

	always #2 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Decode model
	// ------------------------------------------------------------------

	function automatic int hex_digit_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	// Start of a fresh size line; bytes_left is left alone here on purpose
	function automatic void start_size_line();
		dec_phase = P_LINE_START;
		size_acc = '0;
		digits_closed = 1'b0;
		prev_cr = 1'b0;
	endfunction

	function automatic void decoder_state_reset();
		start_size_line();
		bytes_left = '0;
	endfunction

	// Advance the model by one body byte and return the beat it yields
	function automatic cbd_result_t chunk_decode(input logic [7:0] b, input logic last);
		cbd_result_t     r;
		int              h;
		longint unsigned grown;
		r = '0;
		r.end_status = ST_ZERO;
		h = hex_digit_value(b);
		case (dec_phase)
			P_LINE_START, P_LINE: begin
				dec_phase = P_LINE;
				if (h >= 0 && !digits_closed) begin
					// accumulate the size, pinned at the top of the counter range
					grown = 64'(size_acc) * 64'd16 + 64'(h);
					size_acc = (grown > SIZE_CAP) ? '1 : grown[SIZE_BITS_DEF-1:0];
				end else if (h < 0) begin
					digits_closed = 1'b1;
				end
				if (b == CHAR_LF && prev_cr) begin
					if (size_acc == 0) begin
						dec_phase = P_DONE;
					end else begin
						bytes_left = size_acc;
						dec_phase = P_DATA;
					end
					prev_cr = 1'b0;
				end else begin
					prev_cr = (b == CHAR_CR);
				end
			end
			P_DATA: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				bytes_left = bytes_left - 1'b1;
				if (bytes_left == 0) dec_phase = P_SKIP_A;
			end
			P_SKIP_A: dec_phase = P_SKIP_B;
			P_SKIP_B: start_size_line();
			default: ;  // after the zero chunk every byte is dropped
		endcase
		if (last) begin
			r.finished = 1'b1;
			case (dec_phase)
				P_LINE:                           r.end_status = ST_NO_CRLF;
				P_DATA:                           r.end_status = ST_TRUNC;
				P_LINE_START, P_SKIP_A, P_SKIP_B: r.end_status = ST_CLEAN;
				default:                          r.end_status = ST_ZERO;
			endcase
			decoder_state_reset();
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Handshake helpers
	// ------------------------------------------------------------------

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one byte and hold it until the block takes it
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		body_byte <= b;
		body_end <= last;
		do @(posedge clk); while (in_stall);
		decoded_q.push_back(chunk_decode(b, last));
		bytes_sent++;
	endtask

	// Send body_q up to and including end_at, marking that byte as the last one
	task automatic send_body(input int end_at);
		for (int i = 0; i <= end_at; i++) send_byte(body_q[i], i == end_at);
	endtask

	// Drop valid and wait for every owed beat to come out
	task automatic wait_payload_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: a forced hold-off takes priority, otherwise random stall runs while rx_idle_on is set
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!rx_idle_on) begin
			out_stall <= 1'b0;
		end else if (stall_run > 0) begin
			out_stall <= 1'b1;
			stall_run <= stall_run - 1;
		end else begin
			out_stall <= 1'b0;
			stall_run <= pick_gap();
		end
	end

	// Compare every accepted result beat against the oldest decoded beat
	always @(posedge clk) begin : check_results
		cbd_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				$error("result beat with no body byte pending");
				errors++;
			end else begin
				want = decoded_q.pop_front();
				if (payload_byte !== want.payload_byte) begin
					$error("payload_byte: expected %02h, got %02h", want.payload_byte,
						payload_byte);
					errors++;
				end
				if (payload_valid !== want.payload_valid) begin
					$error("payload_valid: expected %0d, got %0d", want.payload_valid,
						payload_valid);
					errors++;
				end
				if (finished !== want.finished) begin
					$error("finished: expected %0d, got %0d", want.finished, finished);
					errors++;
				end
				if (end_status !== want.end_status) begin
					$error("end_status: expected %0d, got %0d", want.end_status, end_status);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Body construction
	// ------------------------------------------------------------------

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 10) return 8'h30 + 8'(nib);
		return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
	endfunction

	// Size line: hex digits in mixed case, maybe leading zeros, no digits for size zero, or an extension
	task automatic add_size_line(input int unsigned sz);
		int         nd;
		logic [7:0] ext;
		if (sz == 0 && $urandom_range(0, 4) == 0) begin
			// empty size: no digits at all
		end else begin
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) body_q.push_back("0");
			nd = 1;
			while (nd < 8 && (sz >> (4 * nd)) != 0) nd++;
			for (int k = nd - 1; k >= 0; k--)
				body_q.push_back(hex_char(4'(sz >> (4 * k)), 1'($urandom_range(0, 1))));
		end
		if ($urandom_range(0, 3) == 0) begin
			// extension: anything but LF, so a lone CR inside must not end the line
			body_q.push_back(";");
			repeat ($urandom_range(0, 6)) begin
				ext = 8'($urandom_range(0, 254));
				if (ext >= CHAR_LF) ext++;
				body_q.push_back(ext);
			end
		end
		add_str("\r\n");
	endtask

	// Well-formed chunked body, usually closed by a zero chunk and trailer noise
	task automatic build_chunked_body();
		int unsigned sz;
		body_q.delete();
		repeat ($urandom_range(0, 4)) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			add_size_line(sz);
			repeat (sz) body_q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 7) == 0) begin
				// skipped bytes are not checked, so they need not be CRLF
				body_q.push_back(8'($urandom_range(0, 255)));
				body_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				add_str("\r\n");
			end
		end
		if ($urandom_range(0, 9) != 0) begin
			add_size_line(0);
			repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom_range(0, 255)));
		end
		if (body_q.size() == 0) body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Chunk with a size far beyond what follows, often past the counter limit
	task automatic build_oversized_chunk();
		body_q.delete();
		if ($urandom_range(0, 1) == 0) begin
			add_size_line($urandom());
		end else begin
			repeat ($urandom_range(8, 12)) body_q.push_back($urandom_range(0, 1) ? "F" : "f");
			add_str("\r\n");
		end
		repeat ($urandom_range(0, 6)) body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	// Short junk leaning on the characters the size parser cares about
	task automatic build_noise();
		string alphabet;
		alphabet = "09afAFg\r\n; ";
		body_q.delete();
		repeat ($urandom_range(1, 16)) begin
			if ($urandom_range(0, 2) == 0)
				body_q.push_back(8'($urandom_range(0, 255)));
			else
				body_q.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
		end
	endtask

	// One random body: mostly well formed, some cut short, some broken
	task automatic send_random_body();
		int kind;
		int end_at;
		kind = $urandom_range(0, 99);
		if (kind < 70) build_chunked_body();
		else if (kind < 80) build_oversized_chunk();
		else build_noise();
		end_at = body_q.size() - 1;
		if ($urandom_range(0, 3) == 0) end_at = $urandom_range(0, body_q.size() - 1);
		send_body(end_at);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_cases();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		// empty size line ends as a zero chunk; the byte after it is dropped
		body_q.delete();
		add_str("\r\nZ");
		send_body(body_q.size() - 1);
		// one-byte chunk: ';' closes the digits so the 'A' after it does not count,
		// and the two skipped bytes are not CRLF; ends clean at a line start
		body_q.delete();
		add_str("1;A\r\n");
		body_q.push_back(8'hFF);
		body_q.push_back(8'h00);
		body_q.push_back(8'h00);
		send_body(body_q.size() - 1);
		// size saturates, then the data is cut short
		body_q.delete();
		add_str("fFFFFFFFF\r\n");
		body_q.push_back(8'h80);
		send_body(body_q.size() - 1);
		// body stops inside the size line
		body_q.delete();
		add_str("5");
		send_body(0);
		wait_payload_drained();
	endtask

	task automatic test_random_bodies(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (bytes_sent < stop_at) send_random_body();
	endtask

	task automatic test_streaming_no_idle(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (bytes_sent < stop_at) send_random_body();
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_output_backpressure(input int count);
		int stop_at;
		wait_payload_drained();
		stop_at = bytes_sent + count;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		hold_toggle = ~hold_toggle;
		while (bytes_sent < stop_at) send_random_body();
	endtask

	// Sender sometimes pauses until the block has emptied after a body
	task automatic test_pause_until_drained(input int count);
		int stop_at;
		stop_at = bytes_sent + count;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		while (bytes_sent < stop_at) begin
			send_random_body();
			if ($urandom_range(0, 2) == 0) wait_payload_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		body_byte = 8'h00;
		body_end = 1'b0;
		decoder_state_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_bodies(900);
		test_streaming_no_idle(250);
		test_output_backpressure(80);
		test_pause_until_drained(250);
		test_random_bodies(100);

		wait_payload_drained();
		repeat (4) @(posedge clk);
		if (errors == 0 && decoded_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
